[sv/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the weighted multi-pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int NODES    = 4096;
    localparam int ALPHABET = 26;
    localparam int NW       = $clog2(NODES);
    localparam int LW       = 5;
    localparam int GDEPTH   = NODES * 32;
    localparam int GAW      = $clog2(GDEPTH);

    localparam logic [2:0] ACT_LETTER = 3'd0;
    localparam logic [2:0] ACT_END    = 3'd1;
    localparam logic [2:0] ACT_BUILD  = 3'd2;
    localparam logic [2:0] ACT_TEXT   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_PHASE = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    typedef enum logic [4:0] {
        S_RST, S_CLR, S_IDLE, S_DEC, S_INS_RD, S_INS_WR, S_END_WR,
        S_TXT_RD, S_TXT_RD2, S_TXT_CW, S_TXT_ACC,
        S_B_INIT, S_B_RLOAD, S_B_RCHK, S_B_RCW,
        S_B_POP, S_B_POPW, S_B_FLD, S_B_KRD, S_B_KCHK, S_B_TRD, S_B_TCHK,
        S_B_WRW, S_B_WRCW, S_B_NEXT, S_OUT
    } state_t;

    typedef struct packed {
        state_t st;
    } cmd_t;

    typedef struct packed {
        logic built;
    } sts_t;

endpackage

[sv/weighted_multi_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// weighted_multi_pattern_matcher
// Weighted Aho-Corasick matcher: trie load, breadth-first build, text scan.
// ----------------------------------------------------------------------------
// latency to m_valid: S_DEC, then INS_RD and INS_WR, END_WR, or TXT_RD to TXT_ACC
// throughput: one transaction in flight; the next item waits for m_ready in S_OUT
// build: RLOAD/RCHK/RCW per root slot; POP/POPW/FLD per node; KRD..TCHK, NEXT per letter
// reset and clear: a sweep over all NODES*32 goto entries before s_ready
module weighted_multi_pattern_matcher import wpm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic [LW-1:0]        s_letter,
    input  logic signed [31:0]   s_weight,
    input  logic                 s_new_text,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [47:0]   m_match_sum,
    output logic signed [47:0]   m_running_total,
    output logic [NW-1:0]        m_node_index,
    output logic [1:0]           m_status
);
    cmd_t cmd;
    sts_t sts;
    logic [2:0] act;
    logic [LW-1:0] let_in;
    logic done_clr, child_nz, q_more, let_last;

    wpm_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .m_ready, .act, .let_in, .sts, .done_clr,
        .child_nz, .q_more, .let_last, .cmd, .s_ready, .m_valid
    );

    wpm_dp u_dp (
        .aclk, .aresetn, .cmd, .s_valid, .s_ready, .s_action, .s_letter, .s_weight,
        .s_new_text, .act, .let_in, .sts, .done_clr, .child_nz, .q_more,
        .let_last, .m_match_sum, .m_running_total, .m_node_index, .m_status
    );
endmodule

[sv/wpm_ram.sv]
// ----------------------------------------------------------------------------
// wpm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[sv/wpm_ctrl.sv]
// ----------------------------------------------------------------------------
// wpm_ctrl
// Sequencer for insert, build, scan and clear.
// ----------------------------------------------------------------------------
module wpm_ctrl import wpm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic m_ready,
    input  logic [2:0] act,
    input  logic [LW-1:0] let_in,
    input  sts_t sts,
    input  logic done_clr,
    input  logic child_nz,
    input  logic q_more,
    input  logic let_last,
    output cmd_t cmd,
    output logic s_ready,
    output logic m_valid
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RST;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_RST:    if (done_clr) state_next = S_IDLE;
            S_CLR:    if (done_clr) state_next = S_OUT;
            S_IDLE:   if (s_valid) state_next = S_DEC;
            S_DEC: begin
                state_next = S_OUT;
                case (act)
                    ACT_LETTER: if (!sts.built && let_in < LW'(ALPHABET))
                        state_next = S_INS_RD;
                    ACT_END:    if (!sts.built) state_next = S_END_WR;
                    ACT_BUILD:  if (!sts.built) state_next = S_B_INIT;
                    ACT_TEXT:   if (sts.built && let_in < LW'(ALPHABET))
                        state_next = S_TXT_RD;
                    ACT_CLEAR:  state_next = S_CLR;
                    default:    state_next = S_OUT;
                endcase
            end
            S_INS_RD:  state_next = S_INS_WR;
            S_INS_WR:  state_next = S_OUT;
            S_END_WR:  state_next = S_OUT;
            S_TXT_RD:  state_next = S_TXT_RD2;
            S_TXT_RD2: state_next = S_TXT_CW;
            S_TXT_CW:  state_next = S_TXT_ACC;
            S_TXT_ACC: state_next = S_OUT;
            S_B_INIT:  state_next = S_B_RLOAD;
            S_B_RLOAD: state_next = S_B_RCHK;
            S_B_RCHK:  state_next = S_B_RCW;
            S_B_RCW:   state_next = let_last ? S_B_POP : S_B_RLOAD;
            S_B_POP:   state_next = q_more ? S_B_POPW : S_OUT;
            S_B_POPW:  state_next = S_B_FLD;
            S_B_FLD:   state_next = S_B_KRD;
            S_B_KRD:   state_next = S_B_KCHK;
            S_B_KCHK:  state_next = S_B_TRD;
            S_B_TRD:   state_next = S_B_TCHK;
            S_B_TCHK:  state_next = child_nz ? S_B_WRW : S_B_NEXT;
            S_B_WRW:   state_next = S_B_WRCW;
            S_B_WRCW:  state_next = S_B_NEXT;
            S_B_NEXT:  state_next = let_last ? S_B_POP : S_B_KRD;
            S_OUT:     if (m_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.st  = state_reg;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT);
    end
endmodule

[sv/wpm_dp.sv]
// ----------------------------------------------------------------------------
// wpm_dp
// Datapath: trie memories, failure queue, scan and running total.
// ----------------------------------------------------------------------------
module wpm_dp import wpm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    input  logic s_valid,
    input  logic s_ready,
    input  logic [2:0] s_action,
    input  logic [LW-1:0] s_letter,
    input  logic signed [31:0] s_weight,
    input  logic s_new_text,
    output logic [2:0] act,
    output logic [LW-1:0] let_in,
    output sts_t sts,
    output logic done_clr,
    output logic child_nz,
    output logic q_more,
    output logic let_last,
    output logic signed [47:0] m_match_sum,
    output logic signed [47:0] m_running_total,
    output logic [NW-1:0] m_node_index,
    output logic [1:0] m_status
);
    localparam logic signed [48:0] MAX48 = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] MIN48 = -49'sh0_8000_0000_0000;

    logic [2:0] act_reg;
    logic [LW-1:0] let_reg;
    logic signed [31:0] w_reg;
    logic nt_reg;
    logic [NW-1:0] ncnt_reg, icur_reg, scur_reg, node_reg;
    logic built_reg;
    logic signed [47:0] tot_reg, match_reg;
    logic [1:0] st_reg;
    logic [NW:0] clr_reg;
    logic [NW:0] head_reg, tail_reg;
    logic [NW-1:0] k_reg, f_reg, ch_reg;
    logic [LW-1:0] c_reg;
    logic signed [47:0] cwt_reg;
    logic need_new;

    // memories
    logic g_we; logic [GAW-1:0] g_a; logic [NW-1:0] g_wd, g_rd;
    logic f_we; logic [NW-1:0] f_a, f_wd, f_rd;
    logic w_we; logic [NW-1:0] w_a; logic [31:0] w_wd, w_rd;
    logic c_we; logic [NW-1:0] c_a; logic [47:0] c_wd, c_rd;
    logic q_we; logic [NW-1:0] q_a, q_wd, q_rd;

    wpm_ram #(.WIDTH(NW), .DEPTH(GDEPTH)) u_goto
        (.aclk, .we(g_we), .addr(g_a), .wdata(g_wd), .rdata(g_rd));
    wpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail
        (.aclk, .we(f_we), .addr(f_a), .wdata(f_wd), .rdata(f_rd));
    wpm_ram #(.WIDTH(32), .DEPTH(NODES)) u_wt
        (.aclk, .we(w_we), .addr(w_a), .wdata(w_wd), .rdata(w_rd));
    wpm_ram #(.WIDTH(48), .DEPTH(NODES)) u_cw
        (.aclk, .we(c_we), .addr(c_a), .wdata(c_wd), .rdata(c_rd));
    wpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_q
        (.aclk, .we(q_we), .addr(q_a), .wdata(q_wd), .rdata(q_rd));

    function automatic logic [GAW-1:0] gaddr(input logic [NW-1:0] n, input logic [LW-1:0] l);
        gaddr = {n, l};
    endfunction

    logic signed [48:0] sum;
    assign sum = 49'(tot_reg) + 49'($signed(c_rd));

    assign act      = act_reg;
    assign let_in   = let_reg;
    assign sts.built = built_reg;
    assign done_clr = clr_reg[NW];
    assign need_new = (g_rd == '0);
    assign child_nz = (ch_reg != '0);
    assign q_more   = (head_reg < tail_reg);
    assign let_last = (c_reg == LW'(ALPHABET - 1));

    // clear sweep touches goto rows one letter slot per cycle through a 32 slot pass
    logic [GAW:0] gclr_reg;

    always_comb begin
        g_we = 1'b0; g_a = gaddr(icur_reg, let_reg); g_wd = '0;
        f_we = 1'b0; f_a = k_reg; f_wd = '0;
        w_we = 1'b0; w_a = ch_reg; w_wd = '0;
        c_we = 1'b0; c_a = ch_reg; c_wd = '0;
        q_we = 1'b0; q_a = head_reg[NW-1:0]; q_wd = ch_reg;
        case (cmd.st)
            S_CLR, S_RST: begin
                g_we = ~gclr_reg[GAW]; g_a = gclr_reg[GAW-1:0];
                f_we = 1'b1; f_a = gclr_reg[NW-1:0];
                w_we = 1'b1; w_a = gclr_reg[NW-1:0];
            end
            S_INS_RD: g_a = gaddr(icur_reg, let_reg);
            S_INS_WR: begin
                g_a  = gaddr(icur_reg, let_reg);
                g_we = need_new && (32'(ncnt_reg) + 32'd1 < 32'(NODES));
                g_wd = ncnt_reg + 1'b1;
            end
            S_END_WR: begin
                w_we = 1'b1; w_a = icur_reg; w_wd = w_reg;
            end
            S_TXT_RD:  g_a = gaddr(nt_reg ? '0 : scur_reg, let_reg);
            S_TXT_RD2: g_a = gaddr(nt_reg ? '0 : scur_reg, let_reg);
            S_TXT_CW:  c_a = scur_reg;
            S_TXT_ACC: c_a = scur_reg;
            S_B_INIT: begin
                c_we = 1'b1; c_a = '0; c_wd = '0;
            end
            S_B_RLOAD: begin g_a = gaddr('0, c_reg); w_a = g_rd; end
            S_B_RCHK: begin
                g_a = gaddr('0, c_reg);
                w_a = g_rd;
                if (g_rd != '0) begin
                    f_we = 1'b1; f_a = g_rd; f_wd = '0;
                    q_we = 1'b1; q_a = tail_reg[NW-1:0]; q_wd = g_rd;
                end
            end
            S_B_RCW: begin
                c_we = (ch_reg != '0); c_a = ch_reg; c_wd = 48'($signed(w_rd));
            end
            S_B_POP, S_B_POPW: q_a = head_reg[NW-1:0];
            S_B_FLD:  f_a = q_rd;
            S_B_KRD:  g_a = gaddr(k_reg, c_reg);
            S_B_KCHK: g_a = gaddr(f_reg, c_reg);
            S_B_TRD:  g_a = gaddr(f_reg, c_reg);
            S_B_TCHK: begin
                g_a = gaddr(k_reg, c_reg);
                if (ch_reg == '0) begin
                    g_we = 1'b1; g_wd = g_rd;
                end
                c_a = g_rd; w_a = ch_reg;
            end
            S_B_WRW: begin
                c_a = cwt_reg[NW-1:0]; w_a = ch_reg;
            end
            S_B_WRCW: begin
                f_we = 1'b1; f_a = ch_reg; f_wd = cwt_reg[NW-1:0];
                c_we = 1'b1; c_a = ch_reg;
                c_wd = 48'($signed(w_rd)) + (cwt_reg[NW-1:0] == '0 ? 48'sd0 : c_rd);
                q_we = (tail_reg < (NW+1)'(NODES)); q_a = tail_reg[NW-1:0]; q_wd = ch_reg;
            end
            default: ;
        endcase
    end

    // child's own weight: read at RCHK for root children
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gclr_reg <= '0; clr_reg <= '0; built_reg <= 1'b0;
            ncnt_reg <= '0; icur_reg <= '0; scur_reg <= '0; tot_reg <= '0;
        end else begin
            case (cmd.st)
                S_CLR, S_RST: begin
                    if (!gclr_reg[GAW]) gclr_reg <= gclr_reg + 1'b1;
                    clr_reg <= {gclr_reg[GAW], {NW{1'b0}}};
                    built_reg <= 1'b0; ncnt_reg <= '0; icur_reg <= '0;
                    scur_reg <= '0; tot_reg <= '0;
                    match_reg <= '0; st_reg <= ST_OK; node_reg <= '0;
                end
                S_IDLE: begin
                    gclr_reg <= '0; clr_reg <= '0;
                    if (s_valid && s_ready) begin
                        act_reg <= s_action; let_reg <= s_letter;
                        w_reg <= s_weight; nt_reg <= s_new_text;
                    end
                end
                S_DEC: begin
                    match_reg <= '0; st_reg <= ST_PHASE;
                    node_reg <= built_reg ? scur_reg : icur_reg;
                    c_reg <= '0; head_reg <= '0; tail_reg <= '0;
                end
                S_INS_WR: begin
                    st_reg <= ST_OK;
                    if (!need_new) begin
                        icur_reg <= g_rd; node_reg <= g_rd;
                    end else if (32'(ncnt_reg) + 32'd1 < 32'(NODES)) begin
                        ncnt_reg <= ncnt_reg + 1'b1;
                        icur_reg <= ncnt_reg + 1'b1; node_reg <= ncnt_reg + 1'b1;
                    end else begin
                        st_reg <= ST_FULL; node_reg <= icur_reg;
                    end
                end
                S_END_WR: begin
                    st_reg <= ST_OK; icur_reg <= '0; node_reg <= '0;
                end
                S_TXT_RD: if (nt_reg) tot_reg <= '0;
                S_TXT_RD2: scur_reg <= g_rd;
                S_TXT_ACC: begin
                    match_reg <= c_rd; node_reg <= scur_reg;
                    if (sum > MAX48) begin
                        tot_reg <= MAX48[47:0]; st_reg <= ST_OVF;
                    end else if (sum < MIN48) begin
                        tot_reg <= MIN48[47:0]; st_reg <= ST_OVF;
                    end else begin
                        tot_reg <= sum[47:0]; st_reg <= ST_OK;
                    end
                end
                S_B_RCHK: begin
                    ch_reg <= g_rd;
                    if (g_rd != '0) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                end
                S_B_RCW: c_reg <= let_last ? '0 : c_reg + 1'b1;
                S_B_POP: begin
                    if (!q_more) begin
                        built_reg <= 1'b1; scur_reg <= '0; tot_reg <= '0;
                        node_reg <= '0; st_reg <= ST_OK;
                    end
                end
                S_B_POPW: head_reg <= head_reg + 1'b1;
                S_B_FLD: k_reg <= q_rd;
                S_B_KRD: f_reg <= (k_reg == '0) ? '0 : f_rd;
                S_B_KCHK: ch_reg <= g_rd;
                S_B_TCHK: cwt_reg <= 48'(g_rd);
                S_B_WRCW: if (tail_reg < (NW+1)'(NODES)) tail_reg <= tail_reg + 1'b1;
                S_B_NEXT: c_reg <= let_last ? '0 : c_reg + 1'b1;
                default: ;
            endcase
        end
    end

    assign m_match_sum     = match_reg;
    assign m_running_total = tot_reg;
    assign m_node_index    = node_reg;
    assign m_status        = st_reg;
endmodule
